// File: hw/rtl/cube_map_texel_address_top_assert.svh
// Assertion macros shared by the cube map texel address RTL.
// Included by the top level, the only module that carries concurrent checks; no other dependencies.
`ifndef CUBE_MAP_TEXEL_ADDRESS_TOP_ASSERT_SVH
`define CUBE_MAP_TEXEL_ADDRESS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CMTA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cmta assertion failed");

// Next-cycle implication, disabled while in reset.
`define CMTA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cmta assertion failed");

`endif

// File: hw/rtl/cmta_pkg.sv
// Shared types and constants for the cube map texel address pipeline.
// No dependencies; used by every cmta module and the top level.
`timescale 1ns / 1ps
package cmta_pkg;

    localparam int MAX_FACE_SIDE_DEF  = 2048;
    localparam int COMPONENT_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int SIDE_RESET = 256;

    localparam int FACE_W  = 3;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 11;
    localparam int INDEX_W = 22;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FACE_WIDTH  = 4'd0,
        REG_FACE_HEIGHT = 4'd1
    } t_cfg_reg;

    typedef enum logic [FACE_W-1:0] {
        FACE_PX = 3'd0,
        FACE_NX = 3'd1,
        FACE_PY = 3'd2,
        FACE_NY = 3'd3,
        FACE_PZ = 3'd4,
        FACE_NZ = 3'd5
    } t_face;

    // Sideband that rides along with each item through the pipeline.
    typedef struct packed {
        t_face face;
        logic  zero;
    } t_item_info;

endpackage

// File: hw/rtl/cube_map_texel_address_top.sv
// Throughput: one item per cycle while the output does not stall; the divider is fully
// pipelined, one quotient bit per stage. Items pass cmta_face_sel, cmta_div, cmta_index.
// Each stage holds its item while the stage after it is full, so stalls never drop or repeat.
// Reset (i_rst_n low, synchronous) empties all stages and sets both face sizes to 256.
// Depends on cmta_pkg, cmta_face_sel, cmta_div, cmta_index and the assertion header.
`timescale 1ns / 1ps
`include "cube_map_texel_address_top_assert.svh"
module cube_map_texel_address_top #(
    parameter int MAX_FACE_SIDE  = cmta_pkg::MAX_FACE_SIDE_DEF,
    parameter int COMPONENT_BITS = cmta_pkg::COMPONENT_BITS_DEF,
    localparam int IN_TDATA_W    = ((3 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes: index 0 face_width, 1 face_height; always ready.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cmta_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cmta_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, low bit up: dir_x, dir_y, dir_z (COMPONENT_BITS each), zero pad.
    input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, low bit up: face_code(3), texel_col(11), texel_row(11), texel_index(22), pad.
    output logic [cmta_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: zero_direction.
    output logic                                m_axis_tuser
);

    localparam int CB = COMPONENT_BITS;
    localparam int QW = $clog2(MAX_FACE_SIDE);      // quotient bits: coordinate < side
    localparam int SW = $clog2(MAX_FACE_SIDE + 1);  // bits of an effective side
    localparam int NW = CB + QW;                    // scaled numerator bits

    logic [cmta_pkg::CFG_DATA_W-1:0] r_face_width, r_face_height;
    logic [SW-1:0] eff_w, eff_h;
    logic [QW-1:0] w_m1, h_m1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= cmta_pkg::CFG_DATA_W'(cmta_pkg::SIDE_RESET);
            r_face_height <= cmta_pkg::CFG_DATA_W'(cmta_pkg::SIDE_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cmta_pkg::REG_FACE_WIDTH:  r_face_width  <= i_cfg_data;
                cmta_pkg::REG_FACE_HEIGHT: r_face_height <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Clamp the sizes: zero acts as one, anything above the maximum as the maximum.
    function automatic logic [SW-1:0] eff_side(input logic [cmta_pkg::CFG_DATA_W-1:0] v);
        logic [SW-1:0] s;
        if (v == '0) begin
            s = SW'(1);
        end else if (32'(v) > 32'(MAX_FACE_SIDE)) begin
            s = SW'(MAX_FACE_SIDE);
        end else begin
            s = SW'(v);
        end
        return s;
    endfunction

    assign eff_w = eff_side(r_face_width);
    assign eff_h = eff_side(r_face_height);
    assign w_m1  = QW'(eff_w - SW'(1));
    assign h_m1  = QW'(eff_h - SW'(1));

    // Stage wiring.
    logic                 fs_vld, fs_rdy;
    logic [NW-1:0]        fs_num_u, fs_num_v;
    logic [CB+1:0]        fs_den;
    cmta_pkg::t_item_info fs_info;
    logic                 dv_vld, dv_rdy;
    logic [QW-1:0]        dv_q_u, dv_q_v;
    cmta_pkg::t_item_info dv_info;

    logic [cmta_pkg::FACE_W-1:0]  out_face;
    logic [cmta_pkg::COL_W-1:0]   out_col;
    logic [cmta_pkg::ROW_W-1:0]   out_row;
    logic [cmta_pkg::INDEX_W-1:0] out_index;
    logic                         out_zero;

    // Face pick and numerator scaling.
    cmta_face_sel #(.CB(CB), .QW(QW), .NW(NW)) u_face_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_x     (s_axis_tdata[CB-1:0]),
        .i_y     (s_axis_tdata[2*CB-1:CB]),
        .i_z     (s_axis_tdata[3*CB-1:2*CB]),
        .i_w_m1  (w_m1),
        .i_h_m1  (h_m1),
        .o_vld   (fs_vld),
        .i_rdy   (fs_rdy),
        .o_num_u (fs_num_u),
        .o_num_v (fs_num_v),
        .o_den   (fs_den),
        .o_info  (fs_info)
    );

    // Divide both scaled numerators by twice the major magnitude.
    cmta_div #(.CB(CB), .QW(QW), .NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fs_vld),
        .o_rdy   (fs_rdy),
        .i_num_u (fs_num_u),
        .i_num_v (fs_num_v),
        .i_den   (fs_den),
        .i_info  (fs_info),
        .o_vld   (dv_vld),
        .i_rdy   (dv_rdy),
        .o_q_u   (dv_q_u),
        .o_q_v   (dv_q_v),
        .o_info  (dv_info)
    );

    // Linear index and output register.
    cmta_index #(.QW(QW), .SW(SW)) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dv_vld),
        .o_rdy   (dv_rdy),
        .i_col   (dv_q_u),
        .i_row   (dv_q_v),
        .i_info  (dv_info),
        .i_width (eff_w),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_face  (out_face),
        .o_col   (out_col),
        .o_row   (out_row),
        .o_index (out_index),
        .o_zero  (out_zero)
    );

    assign m_axis_tdata = {1'b0, out_index, out_row, out_col, out_face};
    assign m_axis_tuser = out_zero;

    // A zero direction leaves every coordinate field at zero.
    `CMTA_ASSERT_IMP(a_zero_fields, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, out_face == cmta_pkg::FACE_PX && out_col == '0 && out_row == '0 && out_index == '0)
    // Rounded coordinates never leave the face.
    `CMTA_ASSERT_IMP(a_col_range, i_clk, i_rst_n, m_axis_tvalid, 32'(out_col) < 32'(eff_w))
    `CMTA_ASSERT_IMP(a_row_range, i_clk, i_rst_n, m_axis_tvalid, 32'(out_row) < 32'(eff_h))
    // A result held under backpressure stays valid in the next cycle.
    `CMTA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

// File: hw/rtl/cmta_face_sel.sv
// Face selection, projection and numerator scaling: two pipeline stages.
// Depends on cmta_pkg.
`timescale 1ns / 1ps
module cmta_face_sel #(
    parameter int CB = cmta_pkg::COMPONENT_BITS_DEF,
    parameter int QW = 11,
    parameter int NW = CB + QW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  logic signed [CB-1:0]    i_x,
    input  logic signed [CB-1:0]    i_y,
    input  logic signed [CB-1:0]    i_z,
    input  logic [QW-1:0]           i_w_m1,
    input  logic [QW-1:0]           i_h_m1,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output logic [NW-1:0]           o_num_u,
    output logic [NW-1:0]           o_num_v,
    output logic [CB+1:0]           o_den,
    output cmta_pkg::t_item_info    o_info
);

    logic signed [CB+1:0] x, y, z, nu, nv, ms_x, ms_y, ms_z, su_s, sv_s;
    logic [CB:0] ax, ay, az, a;
    cmta_pkg::t_item_info info_a;
    logic rdy_a, rdy_b;

    logic                 r_va, r_vb;
    logic [CB:0]          r_su, r_sv;
    logic [CB:0]          r_a;
    cmta_pkg::t_item_info r_info_a, r_info_b;
    logic [NW-1:0]        r_num_u, r_num_v;
    logic [CB+1:0]        r_den;
    logic [NW:0]          prod_u, prod_v;

    always_comb begin
        x = (CB+2)'(i_x);
        y = (CB+2)'(i_y);
        z = (CB+2)'(i_z);
        ms_x = x[CB+1] ? -x : x;
        ms_y = y[CB+1] ? -y : y;
        ms_z = z[CB+1] ? -z : z;
        // Magnitudes keep one extra bit so the most negative value stays exact.
        ax = ms_x[CB:0];
        ay = ms_y[CB:0];
        az = ms_z[CB:0];
        info_a.zero = 1'b0;
        if (ax == '0 && ay == '0 && az == '0) begin
            // Divisor of 2 and n + a of zero give zero coordinates.
            a = (CB+1)'(1);
            nu = -(CB+2)'(1);
            nv = -(CB+2)'(1);
            info_a.face = cmta_pkg::FACE_PX;
            info_a.zero = 1'b1;
        end else if (ax >= ay && ax >= az) begin
            a = ax;
            nv = -y;
            if (!x[CB+1]) begin
                info_a.face = cmta_pkg::FACE_PX;
                nu = z;
            end else begin
                info_a.face = cmta_pkg::FACE_NX;
                nu = -z;
            end
        end else if (ay >= az) begin
            a = ay;
            nu = x;
            if (!y[CB+1]) begin
                info_a.face = cmta_pkg::FACE_PY;
                nv = -z;
            end else begin
                info_a.face = cmta_pkg::FACE_NY;
                nv = z;
            end
        end else begin
            a = az;
            nv = -y;
            if (!z[CB+1]) begin
                info_a.face = cmta_pkg::FACE_NZ;
                nu = -x;
            end else begin
                info_a.face = cmta_pkg::FACE_PZ;
                nu = x;
            end
        end
        su_s = nu + (CB+2)'(a);
        sv_s = nv + (CB+2)'(a);
    end

    assign rdy_b = !r_vb || i_rdy;
    assign rdy_a = !r_va || rdy_b;
    assign o_rdy = rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (rdy_a) begin
            r_va <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_vld) begin
            r_su     <= su_s[CB:0];
            r_sv     <= sv_s[CB:0];
            r_a      <= a;
            r_info_a <= info_a;
        end
    end

    // (n + a) * (side - 1) + a, the rounding bias of half the divisor.
    assign prod_u = (NW+1)'(r_su) * (NW+1)'(i_w_m1) + (NW+1)'(r_a);
    assign prod_v = (NW+1)'(r_sv) * (NW+1)'(i_h_m1) + (NW+1)'(r_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (rdy_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_va) begin
            r_num_u  <= prod_u[NW-1:0];
            r_num_v  <= prod_v[NW-1:0];
            r_den    <= {r_a, 1'b0};
            r_info_b <= r_info_a;
        end
    end

    assign o_vld   = r_vb;
    assign o_num_u = r_num_u;
    assign o_num_v = r_num_v;
    assign o_den   = r_den;
    assign o_info  = r_info_b;

endmodule

// File: hw/rtl/cmta_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Depends on cmta_pkg.
`timescale 1ns / 1ps
module cmta_div #(
    parameter int CB = cmta_pkg::COMPONENT_BITS_DEF,
    parameter int QW = 11,
    parameter int NW = CB + QW
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  logic [NW-1:0]           i_num_u,
    input  logic [NW-1:0]           i_num_v,
    input  logic [CB+1:0]           i_den,
    input  cmta_pkg::t_item_info    i_info,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output logic [QW-1:0]           o_q_u,
    output logic [QW-1:0]           o_q_v,
    output cmta_pkg::t_item_info    o_info
);

    // Index k holds what enters stage k; index QW is the last stage's output.
    logic                 v   [QW+1];
    logic                 rdy [QW+1];
    logic [NW-1:0]        ru  [QW+1];
    logic [NW-1:0]        rv  [QW+1];
    logic [QW-1:0]        qu  [QW+1];
    logic [QW-1:0]        qv  [QW+1];
    logic [CB+1:0]        dn  [QW+1];
    cmta_pkg::t_item_info inf [QW+1];

    assign v[0]   = i_vld;
    assign ru[0]  = i_num_u;
    assign rv[0]  = i_num_v;
    assign qu[0]  = '0;
    assign qv[0]  = '0;
    assign dn[0]  = i_den;
    assign inf[0] = i_info;
    assign o_rdy  = rdy[0];
    assign rdy[QW] = i_rdy;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;
        logic                 r_v;
        logic [NW-1:0]        r_ru, r_rv;
        logic [QW-1:0]        r_qu, r_qv;
        logic [CB+1:0]        r_dn;
        cmta_pkg::t_item_info r_inf;
        logic [NW:0]          sh, du, dv;
        logic [NW-1:0]        n_ru, n_rv;
        logic [QW-1:0]        n_qu, n_qv;

        always_comb begin
            sh   = (NW+1)'(dn[k]) << BIT;
            du   = (NW+1)'(ru[k]) - sh;
            dv   = (NW+1)'(rv[k]) - sh;
            n_ru = ru[k];
            n_rv = rv[k];
            n_qu = qu[k];
            n_qv = qv[k];
            if (!du[NW]) begin
                n_ru      = du[NW-1:0];
                n_qu[BIT] = 1'b1;
            end
            if (!dv[NW]) begin
                n_rv      = dv[NW-1:0];
                n_qv[BIT] = 1'b1;
            end
        end

        assign rdy[k] = !r_v || rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (rdy[k]) begin
                r_v <= v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k] && v[k]) begin
                r_ru  <= n_ru;
                r_rv  <= n_rv;
                r_qu  <= n_qu;
                r_qv  <= n_qv;
                r_dn  <= dn[k];
                r_inf <= inf[k];
            end
        end

        assign v[k+1]   = r_v;
        assign ru[k+1]  = r_ru;
        assign rv[k+1]  = r_rv;
        assign qu[k+1]  = r_qu;
        assign qv[k+1]  = r_qv;
        assign dn[k+1]  = r_dn;
        assign inf[k+1] = r_inf;
    end

    assign o_vld  = v[QW];
    assign o_q_u  = qu[QW];
    assign o_q_v  = qv[QW];
    assign o_info = inf[QW];

endmodule

// File: hw/rtl/cmta_index.sv
// Linear texel index (column + row * width) and output register, two stages.
// Depends on cmta_pkg.
`timescale 1ns / 1ps
module cmta_index #(
    parameter int QW = 11,
    parameter int SW = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    output logic                             o_rdy,
    input  logic [QW-1:0]                    i_col,
    input  logic [QW-1:0]                    i_row,
    input  cmta_pkg::t_item_info             i_info,
    input  logic [SW-1:0]                    i_width,
    output logic                             o_vld,
    input  logic                             i_rdy,
    output logic [cmta_pkg::FACE_W-1:0]      o_face,
    output logic [cmta_pkg::COL_W-1:0]       o_col,
    output logic [cmta_pkg::ROW_W-1:0]       o_row,
    output logic [cmta_pkg::INDEX_W-1:0]     o_index,
    output logic                             o_zero
);

    logic                  rdy_c, rdy_d;
    logic                  r_vc, r_vd;
    logic [QW+SW-1:0]      r_prod;
    logic [QW-1:0]         r_col_c, r_row_c;
    cmta_pkg::t_item_info  r_info_c;
    logic [QW+SW:0]        sum;

    logic [cmta_pkg::FACE_W-1:0]  r_face;
    logic [cmta_pkg::COL_W-1:0]   r_col;
    logic [cmta_pkg::ROW_W-1:0]   r_row;
    logic [cmta_pkg::INDEX_W-1:0] r_index;
    logic                         r_zero;

    assign rdy_d = !r_vd || i_rdy;
    assign rdy_c = !r_vc || rdy_d;
    assign o_rdy = rdy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_c) begin
                r_vc <= i_vld;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && i_vld) begin
            r_prod   <= (QW+SW)'(i_row) * (QW+SW)'(i_width);
            r_col_c  <= i_col;
            r_row_c  <= i_row;
            r_info_c <= i_info;
        end
    end

    assign sum = (QW+SW+1)'(r_prod) + (QW+SW+1)'(r_col_c);

    always_ff @(posedge i_clk) begin
        if (rdy_d && r_vc) begin
            r_face  <= r_info_c.face;
            r_col   <= cmta_pkg::COL_W'(r_col_c);
            r_row   <= cmta_pkg::ROW_W'(r_row_c);
            r_index <= cmta_pkg::INDEX_W'(sum);
            r_zero  <= r_info_c.zero;
        end
    end

    assign o_vld   = r_vd;
    assign o_face  = r_face;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_index = r_index;
    assign o_zero  = r_zero;

endmodule

// File: verif/cube_map_texel_address_top_test.sv
// Self-checking testbench for cube_map_texel_address_top: face selection and texel addressing.
// Depends on cmta_pkg and the RTL; holds its own predictor and a small scoreboard class.
`timescale 1ns / 1ps
module cube_map_texel_address_top_test;

    typedef struct packed {
        logic [cmta_pkg::INDEX_W-1:0] index;
        logic [cmta_pkg::ROW_W-1:0]   row;
        logic [cmta_pkg::COL_W-1:0]   col;
        cmta_pkg::t_face              face;
        logic                         zero;
    } t_texel;

    int unsigned mismatch_count = 0;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    class texel_scoreboard;
        t_texel pending[$];

        function void note_item(input t_texel exp_texel);
            pending.push_back(exp_texel);
        endfunction

        task check_result(input t_texel got);
            t_texel want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.face !== want.face) report_mismatch("face_code", got.face, want.face);
            if (got.col !== want.col) report_mismatch("texel_col", got.col, want.col);
            if (got.row !== want.row) report_mismatch("texel_row", got.row, want.row);
            if (got.index !== want.index) report_mismatch("texel_index", got.index, want.index);
            if (got.zero !== want.zero) report_mismatch("zero_direction", got.zero, want.zero);
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [cmta_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [cmta_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [47:0]                     s_axis_tdata = '0;   // dir_x, dir_y, dir_z from bit 0 up
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [cmta_pkg::OUT_TDATA_W-1:0] m_axis_tdata;       // face, col, row, index from bit 0 up
    logic                            m_axis_tuser;        // zero_direction

    cube_map_texel_address_top u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    texel_scoreboard texel_board = new();
    // Shadow copy of the face size registers.
    logic [11:0] width_reg = 12'd256;
    logic [11:0] height_reg = 12'd256;
    int unsigned idle_pct = 31;      // idling chance, percent, both sides
    bit          hold_sink = 1'b0;   // set to make the receiver hold off
    bit          stim_done = 1'b0;

    function automatic longint clamp_side(input logic [11:0] reg_val);
        if (reg_val == 0) return 1;
        if (reg_val > cmta_pkg::MAX_FACE_SIDE_DEF) return cmta_pkg::MAX_FACE_SIDE_DEF;
        return reg_val;
    endfunction

    // Rounded projection onto the face, halves up.
    function automatic longint face_coord(input longint n, input longint a, input longint side);
        return ((n + a) * (side - 1) + a) / (2 * a);
    endfunction

    function automatic t_texel predict_texel(input logic signed [15:0] dx,
                                             input logic signed [15:0] dy,
                                             input logic signed [15:0] dz);
        longint x, y, z, ax, ay, az, a, nu, nv, w, h, c, r;
        t_texel res;
        x = dx; y = dy; z = dz;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        w = clamp_side(width_reg);
        h = clamp_side(height_reg);
        res = '0;
        if (ax == 0 && ay == 0 && az == 0) begin
            res.zero = 1'b1;
            return res;
        end
        if (ax >= ay && ax >= az) begin
            a = ax; nv = -y;
            if (x > 0) begin res.face = cmta_pkg::FACE_PX; nu = z; end
            else begin res.face = cmta_pkg::FACE_NX; nu = -z; end
        end else if (ay >= az) begin
            a = ay; nu = x;
            if (y > 0) begin res.face = cmta_pkg::FACE_PY; nv = -z; end
            else begin res.face = cmta_pkg::FACE_NY; nv = z; end
        end else begin
            a = az; nv = -y;
            if (z > 0) begin res.face = cmta_pkg::FACE_NZ; nu = -x; end
            else begin res.face = cmta_pkg::FACE_PZ; nu = x; end
        end
        c = face_coord(nu, a, w);
        r = face_coord(nv, a, h);
        res.col = c[cmta_pkg::COL_W-1:0];
        res.row = r[cmta_pkg::ROW_W-1:0];
        res.index = cmta_pkg::INDEX_W'(c + r * w);
        return res;
    endfunction

    // Offer one item after random idle gaps; note it when accepted.
    task automatic send_dir(input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dz);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dz, dy, dx};
        do @(posedge i_clk); while (!s_axis_tready);
        texel_board.note_item(predict_texel(dx, dy, dz));
        @(negedge i_clk);
    endtask

    // Write one register once the pipeline has drained.
    task automatic write_face_reg(input cmta_pkg::t_cfg_reg idx, input logic [11:0] value);
        s_axis_tvalid <= 1'b0;
        while (texel_board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == cmta_pkg::REG_FACE_WIDTH) width_reg = value;
        else if (idx == cmta_pkg::REG_FACE_HEIGHT) height_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, or a long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_sink) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Sample results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            texel_board.check_result({m_axis_tdata[46:25], m_axis_tdata[24:14],
                                      m_axis_tdata[13:3],
                                      cmta_pkg::t_face'(m_axis_tdata[2:0]),
                                      m_axis_tuser});
    end

    // Hold the receiver off for a long stretch, counted in cycles here.
    initial begin
        wait (i_rst_n);
        repeat (300) @(negedge i_clk);
        hold_sink = 1'b1;
        repeat (200) @(negedge i_clk);
        hold_sink = 1'b0;
    end

    // Sizes to sweep: reset value, extremes, zero, above-limit values and two other in-range sizes.
    logic [11:0] width_set[6] = '{12'd256, 12'd1, 12'd2048, 12'd0, 12'd4095, 12'd37};
    logic [11:0] height_set[6] = '{12'd256, 12'd2048, 12'd1, 12'd3000, 12'd0, 12'd640};

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: zero direction, every face, ties, extremes, most negative value.
        send_dir(16'd0, 16'd0, 16'd0);
        send_dir(16'd5, 16'd1, 16'hFFFE);
        send_dir(16'hFFFB, 16'd2, 16'd3);
        send_dir(16'd1, 16'd9, 16'd2);
        send_dir(16'd1, 16'hFFF7, 16'd2);
        send_dir(16'd1, 16'd2, 16'd9);
        send_dir(16'd1, 16'd2, 16'hFFF7);
        send_dir(16'd7, 16'd7, 16'd7);
        send_dir(16'hFFF9, 16'd7, 16'd7);
        send_dir(16'd0, 16'd7, 16'hFFF9);
        send_dir(16'h8000, 16'h8000, 16'h8000);
        send_dir(16'h7FFF, 16'h8000, 16'h7FFF);
        send_dir(16'h8000, 16'h7FFF, 16'h8001);
        send_dir(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_dir(16'hFFFF, 16'd0, 16'd0);
        send_dir(16'd0, 16'd0, 16'hFFFF);
        send_dir(16'd4, 16'hFFFC, 16'd4);
        send_dir(16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int phase = 0; phase < 6; phase++) begin
            write_face_reg(cmta_pkg::REG_FACE_WIDTH, width_set[phase]);
            write_face_reg(cmta_pkg::REG_FACE_HEIGHT, height_set[phase]);
            // Second phase runs without idling on either side.
            idle_pct = (phase == 1) ? 0 : 31;
            for (int k = 0; k < 170; k++)
                send_dir(rand_comp(), rand_comp(), rand_comp());
            idle_pct = 31;
        end
        // Unknown register index: ignored by the block and the shadow copy.
        write_face_reg(cmta_pkg::t_cfg_reg'(4'd9), 12'd5);
        for (int k = 0; k < 20; k++)
            send_dir(rand_comp(), rand_comp(), rand_comp());
        s_axis_tvalid <= 1'b0;
        while (texel_board.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        stim_done = 1'b1;
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cmta_pkg.sv
hw/rtl/cmta_face_sel.sv
hw/rtl/cmta_div.sv
hw/rtl/cmta_index.sv
hw/rtl/cube_map_texel_address_top.sv
verif/cube_map_texel_address_top_test.sv
